/* src/ulrb_pkg.sv */
// Package with the opcodes, character constants and transaction types of the UART ring buffers.
`default_nettype none
package ulrb_pkg;

  typedef enum logic [2:0] {
    OP_RX_BYTE  = 3'd0,
    OP_READ     = 3'd1,
    OP_LINE_CON = 3'd2,
    OP_FLUSH_RX = 3'd3,
    OP_WRITE_TX = 3'd4,
    OP_TX_EMPTY = 3'd5
  } op_t;

  localparam logic [7:0] CHR_CR  = 8'd13;
  localparam logic [7:0] CHR_LF  = 8'd10;
  localparam logic [7:0] CHR_NUL = 8'd0;
  localparam logic [7:0] LINE_MAX = 8'hFF;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_enable;
    logic       overflow;
    logic [7:0] lines_waiting;
  } out_item_t;

endpackage
`default_nettype wire

/* src/uart_line_ring_buffers.sv */
// Latency: an accepted transaction's result is registered in p_res_r, then moves to o_res_r
// when the output stage is free, where the registered ring read data joins it.
// Throughput: one transaction per cycle while in_stall is low; each ring memory is read once and
// written at most once per transaction at the accepting edge.
// Reset: pointers, line count, transmit enable and all valid flags clear on rst_n low;
// the ring memories are not cleared, and only a byte from a written entry reaches the result.
`default_nettype none
module uart_line_ring_buffers #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire ulrb_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output ulrb_pkg::out_item_t      out_data
);

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RX_AW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [TX_AW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [7:0]       line_cnt_r, line_cnt_nxt;
  logic             tx_flag_r, tx_flag_nxt;

  logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
  logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
  logic             rx_wr, tx_wr;
  logic             rv, tv, ovf;

  logic                in_fire, p_move;
  logic                p_valid_r;
  ulrb_pkg::out_item_t p_res_r, o_res_r, o_res_nxt;
  logic [7:0]          rx_rd_r, tx_rd_r;
  logic                o_valid_r;

  assign rx_head_inc = (rx_head_r == RX_LAST) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_inc = (rx_tail_r == RX_LAST) ? '0 : rx_tail_r + 1'b1;
  assign tx_head_inc = (tx_head_r == TX_LAST) ? '0 : tx_head_r + 1'b1;
  assign tx_tail_inc = (tx_tail_r == TX_LAST) ? '0 : tx_tail_r + 1'b1;

  assign p_move   = p_valid_r && (!o_valid_r || !out_stall);
  assign in_stall = p_valid_r && !p_move;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    rx_head_nxt  = rx_head_r;
    rx_tail_nxt  = rx_tail_r;
    tx_head_nxt  = tx_head_r;
    tx_tail_nxt  = tx_tail_r;
    line_cnt_nxt = line_cnt_r;
    tx_flag_nxt  = tx_flag_r;
    rx_wr        = 1'b0;
    tx_wr        = 1'b0;
    rv           = 1'b0;
    tv           = 1'b0;
    ovf          = 1'b0;
    if (in_fire) begin
      unique case (in_data.opcode)
        ulrb_pkg::OP_RX_BYTE: begin
          // A full receive ring is discarded wholesale and the byte is lost.
          if (rx_head_inc == rx_tail_r) begin
            rx_head_nxt = rx_tail_r;
            ovf         = 1'b1;
          end else if (in_data.data == ulrb_pkg::CHR_CR) begin
            if (line_cnt_r != ulrb_pkg::LINE_MAX) begin
              line_cnt_nxt = line_cnt_r + 8'd1;
            end
          end else if (in_data.data != ulrb_pkg::CHR_NUL &&
                       in_data.data != ulrb_pkg::CHR_LF) begin
            rx_wr       = 1'b1;
            rx_head_nxt = rx_head_inc;
          end
        end
        ulrb_pkg::OP_READ: begin
          if (rx_tail_r != rx_head_r) begin
            rx_tail_nxt = rx_tail_inc;
            rv          = 1'b1;
          end
        end
        ulrb_pkg::OP_LINE_CON: begin
          if (line_cnt_r != 8'd0) begin
            line_cnt_nxt = line_cnt_r - 8'd1;
          end
        end
        ulrb_pkg::OP_FLUSH_RX: begin
          rx_head_nxt = rx_tail_r;
        end
        ulrb_pkg::OP_WRITE_TX: begin
          tx_head_nxt = tx_head_inc;
          tx_wr       = 1'b1;
          tx_flag_nxt = 1'b1;
        end
        ulrb_pkg::OP_TX_EMPTY: begin
          if (tx_tail_r != tx_head_r) begin
            tx_tail_nxt = tx_tail_inc;
            tv          = 1'b1;
          end else begin
            tx_flag_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r  <= '0;
      rx_tail_r  <= '0;
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
      line_cnt_r <= '0;
      tx_flag_r  <= 1'b0;
    end else begin
      rx_head_r  <= rx_head_nxt;
      rx_tail_r  <= rx_tail_nxt;
      tx_head_r  <= tx_head_nxt;
      tx_tail_r  <= tx_tail_nxt;
      line_cnt_r <= line_cnt_nxt;
      tx_flag_r  <= tx_flag_nxt;
    end
  end

  // The entry at the head is the newest, so a pop reads the slot after the tail.
  always_ff @(posedge clk) begin
    if (rx_wr) begin
      rx_mem[rx_head_inc] <= in_data.data;
    end
    if (in_fire) begin
      rx_rd_r <= rx_mem[rx_tail_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_wr) begin
      tx_mem[tx_head_inc] <= in_data.data;
    end
    if (in_fire) begin
      tx_rd_r <= tx_mem[tx_tail_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_fire) begin
      p_valid_r <= 1'b1;
    end else if (p_move) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_res_r.read_valid    <= rv;
      p_res_r.read_byte     <= '0;
      p_res_r.tx_valid      <= tv;
      p_res_r.tx_byte       <= '0;
      p_res_r.tx_enable     <= tx_flag_nxt;
      p_res_r.overflow      <= ovf;
      p_res_r.lines_waiting <= line_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (p_move) begin
      o_valid_r <= 1'b1;
    end else if (!out_stall) begin
      o_valid_r <= 1'b0;
    end
  end

  always_comb begin
    o_res_nxt           = p_res_r;
    o_res_nxt.read_byte = p_res_r.read_valid ? rx_rd_r : 8'd0;
    o_res_nxt.tx_byte   = p_res_r.tx_valid ? tx_rd_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_res_r <= o_res_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_res_r;

endmodule
`default_nettype wire

/* src/ulrb_checker.sv */
// Port-level checker for the UART ring buffers, bound to the top level.
`default_nettype none
module ulrb_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_stall,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire ulrb_pkg::out_item_t out_data
);

  // A stalled result transaction must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.read_valid || out_data.read_byte == 8'd0) &&
                  (out_data.tx_valid || out_data.tx_byte == 8'd0))
    else $error("byte field not zero without a pop");

  // A byte popped for transmit implies the enable is still set.
  a_tx_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tx_valid |-> out_data.tx_enable)
    else $error("transmit byte sent with enable clear");

  a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> !out_data.read_valid && !out_data.tx_valid)
    else $error("overflow reported together with a pop");

  // The input only backs up behind a result that is itself being held off.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");

endmodule

bind uart_line_ring_buffers ulrb_checker u_ulrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the UART receive and transmit ring buffers with line counting.
`timescale 1ns / 100ps
module tb;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);
  localparam int IDLE_MAX = 12;
  localparam int HOLD_CYCLES = 90;
  localparam int HOLD_AFTER = 300;
  localparam int RANDOM_ITEMS = 1000;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX = 10;
  localparam int DIR_ROWS = 24;
  localparam int SAT_CRS = 270;

  // Opcodes that the block treats as no operation.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef enum int {
    EP_RX_FILL, EP_RX_DRAIN, EP_LINES, EP_TX_FILL, EP_TX_DRAIN, EP_MIXED
  } episode_t;

  typedef struct {
    logic [2:0]          opcode;
    logic [7:0]          data;
    bit                  typed;
    ulrb_pkg::out_item_t want;
  } stim_row_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ulrb_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ulrb_pkg::out_item_t out_data;

  uart_line_ring_buffers #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predicted state of both rings; the pointers wrap naturally as the depths are powers of two.
  logic [7:0]          rx_ring [RX_DEPTH];
  logic [7:0]          tx_ring [TX_DEPTH];
  logic [RX_PTR_W-1:0] rx_newest = '0;
  logic [RX_PTR_W-1:0] rx_oldest = '0;
  logic [TX_PTR_W-1:0] tx_newest = '0;
  logic [TX_PTR_W-1:0] tx_oldest = '0;
  logic [7:0]          lines_model = '0;
  logic                tx_enable_model = 1'b0;

  ulrb_pkg::out_item_t pending_status_q [$];
  int        mismatches = 0;
  int        results_checked = 0;
  int        items_sent = 0;
  int        random_count = 0;
  int        overflows_seen = 0;
  bit        lines_saturated = 1'b0;
  bit        in_random_phase = 1'b0;
  bit        sender_fast = 1'b0;
  bit        hold_request = 1'b0;
  bit        hold_active = 1'b0;
  stim_row_t dir_rows [DIR_ROWS];

  function automatic ulrb_pkg::out_item_t predict_uart(input ulrb_pkg::in_item_t item);
    ulrb_pkg::out_item_t res;
    logic [RX_PTR_W-1:0] rx_next;
    res = '0;
    rx_next = rx_newest + 1'b1;
    case (item.opcode)
      ulrb_pkg::OP_RX_BYTE: begin
        if (rx_next == rx_oldest) begin
          // A full ring is thrown away along with the incoming byte.
          rx_newest = rx_oldest;
          res.overflow = 1'b1;
        end else if (item.data == ulrb_pkg::CHR_CR) begin
          if (lines_model != ulrb_pkg::LINE_MAX) lines_model = lines_model + 1'b1;
        end else if (item.data != ulrb_pkg::CHR_NUL && item.data != ulrb_pkg::CHR_LF) begin
          rx_ring[rx_next] = item.data;
          rx_newest = rx_next;
        end
      end
      ulrb_pkg::OP_READ: begin
        if (rx_oldest != rx_newest) begin
          rx_oldest = rx_oldest + 1'b1;
          res.read_valid = 1'b1;
          res.read_byte = rx_ring[rx_oldest];
        end
      end
      ulrb_pkg::OP_LINE_CON: begin
        if (lines_model != '0) lines_model = lines_model - 1'b1;
      end
      ulrb_pkg::OP_FLUSH_RX: rx_newest = rx_oldest;
      ulrb_pkg::OP_WRITE_TX: begin
        tx_newest = tx_newest + 1'b1;
        tx_ring[tx_newest] = item.data;
        tx_enable_model = 1'b1;
      end
      ulrb_pkg::OP_TX_EMPTY: begin
        if (tx_oldest != tx_newest) begin
          tx_oldest = tx_oldest + 1'b1;
          res.tx_valid = 1'b1;
          res.tx_byte = tx_ring[tx_oldest];
        end else begin
          tx_enable_model = 1'b0;
        end
      end
      default: ;
    endcase
    res.tx_enable = tx_enable_model;
    res.lines_waiting = lines_model;
    return res;
  endfunction

  function automatic logic [7:0] pick_rx_char();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return ulrb_pkg::CHR_CR;
    if (roll == 1) return ulrb_pkg::CHR_LF;
    if (roll == 2) return ulrb_pkg::CHR_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // Called just after a rising edge; returns at the edge that accepts the transaction.
  task automatic send_item(input logic [2:0] op, input logic [7:0] d,
                           input bit typed = 1'b0, input ulrb_pkg::out_item_t want = '0);
    int                  gap;
    ulrb_pkg::in_item_t  item;
    ulrb_pkg::out_item_t predicted;
    item.opcode = op;
    item.data = d;
    gap = (sender_fast || hold_active) ? 0 : $urandom_range(0, IDLE_MAX);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    predicted = predict_uart(item);
    pending_status_q.push_back(typed ? want : predicted);
    items_sent++;
    if (in_random_phase && op <= ulrb_pkg::OP_TX_EMPTY) begin
      random_count++;
      if (random_count == HOLD_AFTER) hold_request = 1'b1;
    end
  endtask

  task automatic run_episode(input episode_t kind, input bit longest);
    int         n;
    logic [2:0] op;
    sender_fast = ($urandom_range(0, 3) == 0);
    case (kind)
      EP_RX_FILL: begin
        n = longest ? 80 : $urandom_range(1, 80);
        repeat (n) send_item(ulrb_pkg::OP_RX_BYTE, pick_rx_char());
      end
      EP_RX_DRAIN: begin
        n = longest ? 80 : $urandom_range(1, 80);
        repeat (n)
          send_item(($urandom_range(0, 7) == 0) ? ulrb_pkg::OP_LINE_CON : ulrb_pkg::OP_READ,
                    8'($urandom_range(0, 255)));
      end
      EP_LINES: begin
        if (longest) begin
          // Flushing first keeps the ring clear of the full case while the count saturates.
          send_item(ulrb_pkg::OP_FLUSH_RX, 8'($urandom_range(0, 255)));
          repeat (SAT_CRS) send_item(ulrb_pkg::OP_RX_BYTE, ulrb_pkg::CHR_CR);
          repeat (3) send_item(ulrb_pkg::OP_LINE_CON, 8'($urandom_range(0, 255)));
        end else begin
          n = $urandom_range(1, 20);
          repeat (n)
            send_item(($urandom_range(0, 1) == 0) ? ulrb_pkg::OP_RX_BYTE
                                                   : ulrb_pkg::OP_LINE_CON,
                      ulrb_pkg::CHR_CR);
        end
      end
      EP_TX_FILL: begin
        n = longest ? 70 : $urandom_range(1, 70);
        repeat (n) send_item(ulrb_pkg::OP_WRITE_TX, 8'($urandom_range(0, 255)));
      end
      EP_TX_DRAIN: begin
        n = longest ? 70 : $urandom_range(1, 70);
        repeat (n) send_item(ulrb_pkg::OP_TX_EMPTY, 8'($urandom_range(0, 255)));
      end
      default: begin
        n = $urandom_range(1, 30);
        repeat (n) begin
          op = 3'($urandom_range(0, 7));
          send_item(op, (op == ulrb_pkg::OP_RX_BYTE) ? pick_rx_char()
                                                      : 8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input ulrb_pkg::out_item_t want,
                                 input ulrb_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%s: expected rv=%0d rb=%h tv=%0d tb=%h en=%0d ovf=%0d lines=%0d",
               what, want.read_valid, want.read_byte, want.tx_valid, want.tx_byte,
               want.tx_enable, want.overflow, want.lines_waiting);
      $display("%s: actual   rv=%0d rb=%h tv=%0d tb=%h en=%0d ovf=%0d lines=%0d",
               what, got.read_valid, got.read_byte, got.tx_valid, got.tx_byte,
               got.tx_enable, got.overflow, got.lines_waiting);
    end
  endtask

  always @(posedge clk) begin : status_check
    ulrb_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_status_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data);
      end else begin
        want = pending_status_q.pop_front();
        if (want.overflow) overflows_seen++;
        if (want.lines_waiting == ulrb_pkg::LINE_MAX) lines_saturated = 1'b1;
        if (out_data.read_valid !== want.read_valid || out_data.read_byte !== want.read_byte ||
            out_data.tx_valid !== want.tx_valid || out_data.tx_byte !== want.tx_byte ||
            out_data.tx_enable !== want.tx_enable || out_data.overflow !== want.overflow ||
            out_data.lines_waiting !== want.lines_waiting)
          report_mismatch("mismatch", want, out_data);
      end
    end
  end

  // Result side: a random hold-off before each transaction, plus one long hold-off.
  initial begin : result_sink
    int wait_cycles;
    int stretch_left;
    bit stretch_fast;
    stretch_left = 0;
    stretch_fast = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(1, 60);
        stretch_fast = ($urandom_range(0, 3) == 0);
      end
      stretch_left--;
      wait_cycles = stretch_fast ? 0 : $urandom_range(0, IDLE_MAX);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    dir_rows[0]  = '{ulrb_pkg::OP_READ, 8'hFF, 1'b1, '0};
    dir_rows[1]  = '{ulrb_pkg::OP_TX_EMPTY, 8'h00, 1'b1, '0};
    dir_rows[2]  = '{ulrb_pkg::OP_LINE_CON, 8'hFF, 1'b1, '0};
    dir_rows[3]  = '{OP_SPARE_B, 8'hFF, 1'b1, '0};
    dir_rows[4]  = '{OP_SPARE_A, 8'h00, 1'b1, '0};
    dir_rows[5]  = '{ulrb_pkg::OP_RX_BYTE, ulrb_pkg::CHR_NUL, 1'b1, '0};
    dir_rows[6]  = '{ulrb_pkg::OP_RX_BYTE, ulrb_pkg::CHR_LF, 1'b1, '0};
    dir_rows[7]  = '{ulrb_pkg::OP_RX_BYTE, ulrb_pkg::CHR_CR, 1'b1,
                     '{lines_waiting: 8'd1, default: '0}};
    dir_rows[8]  = '{ulrb_pkg::OP_RX_BYTE, 8'hFF, 1'b1, '{lines_waiting: 8'd1, default: '0}};
    dir_rows[9]  = '{ulrb_pkg::OP_RX_BYTE, 8'h01, 1'b1, '{lines_waiting: 8'd1, default: '0}};
    dir_rows[10] = '{ulrb_pkg::OP_READ, 8'h00, 1'b1,
                     '{read_valid: 1'b1, read_byte: 8'hFF, lines_waiting: 8'd1, default: '0}};
    dir_rows[11] = '{ulrb_pkg::OP_READ, 8'h00, 1'b1,
                     '{read_valid: 1'b1, read_byte: 8'h01, lines_waiting: 8'd1, default: '0}};
    dir_rows[12] = '{ulrb_pkg::OP_READ, 8'h00, 1'b1, '{lines_waiting: 8'd1, default: '0}};
    dir_rows[13] = '{ulrb_pkg::OP_LINE_CON, 8'h00, 1'b1, '0};
    dir_rows[14] = '{ulrb_pkg::OP_WRITE_TX, 8'h00, 1'b1, '{tx_enable: 1'b1, default: '0}};
    dir_rows[15] = '{ulrb_pkg::OP_WRITE_TX, 8'hFF, 1'b1, '{tx_enable: 1'b1, default: '0}};
    dir_rows[16] = '{ulrb_pkg::OP_TX_EMPTY, 8'h00, 1'b1,
                     '{tx_valid: 1'b1, tx_byte: 8'h00, tx_enable: 1'b1, default: '0}};
    dir_rows[17] = '{ulrb_pkg::OP_TX_EMPTY, 8'h00, 1'b1,
                     '{tx_valid: 1'b1, tx_byte: 8'hFF, tx_enable: 1'b1, default: '0}};
    dir_rows[18] = '{ulrb_pkg::OP_TX_EMPTY, 8'h00, 1'b1, '0};
    dir_rows[19] = '{ulrb_pkg::OP_RX_BYTE, 8'h7E, 1'b0, '0};
    dir_rows[20] = '{ulrb_pkg::OP_FLUSH_RX, 8'h00, 1'b0, '0};
    dir_rows[21] = '{ulrb_pkg::OP_READ, 8'hFF, 1'b0, '0};
    dir_rows[22] = '{ulrb_pkg::OP_WRITE_TX, 8'hA5, 1'b0, '0};
    dir_rows[23] = '{ulrb_pkg::OP_TX_EMPTY, 8'hFF, 1'b0, '0};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      send_item(dir_rows[r].opcode, dir_rows[r].data, dir_rows[r].typed, dir_rows[r].want);

    // Each kind of sequence runs once, at full length but for the mixed kind; then kinds are drawn at random.
    in_random_phase = 1'b1;
    for (int k = EP_RX_FILL; k <= EP_MIXED; k++) run_episode(episode_t'(k), 1'b1);
    while (random_count < RANDOM_ITEMS)
      run_episode(episode_t'($urandom_range(EP_RX_FILL, EP_MIXED)), 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input transactions (%0d random) and %0d checked results.",
             items_sent, random_count, results_checked);
    $display("Receive overflows: %0d; line count saturated: %0d; mismatches: %0d.",
             overflows_seen, lines_saturated, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
